FILE: rtl/core/srks_pkg.sv
`timescale 1ns / 1ps

package srks_pkg;

  // keypad matrix size
  localparam int unsigned Rows = 5;
  localparam int unsigned Cols = 5;

  // column bits at or above the column count are ignored
  localparam logic [7:0] ColMask = (Cols >= 8) ? 8'hFF : 8'((1 << Cols) - 1);

  // register reset values
  localparam logic [7:0]  SettleTicksRst  = 8'd50;
  localparam logic [15:0] ScanGapTicksRst = 16'd20000;
  localparam logic [3:0]  StableNeededRst = 4'd3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SETTLE_TICKS   = 2'd0,
    CFG_SCAN_GAP_TICKS = 2'd1,
    CFG_STABLE_NEEDED  = 2'd2
  } cfg_idx_e;

  // scan sequencer phases
  typedef enum logic [2:0] {
    PH_SO_SETUP  = 3'd0,
    PH_SO_CLOCK  = 3'd1,
    PH_LATCH_A   = 3'd2,
    PH_SETTLE    = 3'd3,
    PH_LATCH_B   = 3'd4,
    PH_SI_SAMPLE = 3'd5,
    PH_SI_CLOCK  = 3'd6,
    PH_GAP       = 3'd7
  } phase_e;

endpackage

FILE: rtl/core/shift_register_keypad_scanner.sv
// Keypad matrix scanner working through a shared shift-register pin set. Every
// request on the input channel is one timing tick and carries the level sampled
// on the data line; every tick gives exactly one result holding the pin levels
// for that tick (shift clock, latch, data out, data drive enable) plus the scan
// status (scan done, debounced key press, latest key code). Per row the row's
// active-low select byte is shifted out msb first, the latch is pulsed low
// twice with settle_ticks between, then eight column bits are shifted in. The
// first pressed column in the lowest pressed row gives code row*5+col+1, or 0
// when nothing is pressed; scan_gap_ticks idle ticks follow each scan. A press
// is reported once per hold after stable_needed repeated equal codes. Rate is
// one request per clock: the whole tick update is a single pass of logic from
// the state registers into the result register, and a new request is taken
// whenever the result register is empty or is being emptied in the same cycle.
// A result appears in the cycle after its request is accepted. Configuration
// writes are always ready and must only be issued while the block is idle.
`timescale 1ns / 1ps

module shift_register_keypad_scanner
  import srks_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        serial_in_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        shift_clock_o,
  output logic        shift_latch_o,
  output logic        serial_out_o,
  output logic        data_drive_o,
  output logic        scan_done_o,
  output logic        key_press_o,
  output logic [4:0]  key_code_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // configuration registers
  logic [7:0]  settle_ticks_q;
  logic [15:0] scan_gap_ticks_q;
  logic [3:0]  stable_needed_q;

  // scan state
  phase_e      phase_q, phase_d;
  logic [2:0]  row_index_q, row_index_d;
  logic [2:0]  bit_count_q, bit_count_d;
  logic [7:0]  shift_byte_q, shift_byte_d;
  logic [15:0] wait_count_q, wait_count_d;
  logic [4:0]  last_code_q, last_code_d;
  logic [7:0]  repeat_count_q, repeat_count_d;
  logic        press_reported_q, press_reported_d;

  // result register
  logic        out_valid_q;
  logic        clk_q, clk_d;
  logic        latch_q, latch_d;
  logic        sout_q, sout_d;
  logic        drive_q, drive_d;
  logic        done_q, done_d;
  logic        press_q, press_d;
  logic [4:0]  code_q;

  logic        accept;
  logic [7:0]  row_byte;
  logic [7:0]  pressed;
  logic [2:0]  first_col;
  logic [6:0]  code_full;
  logic [4:0]  code;
  logic        last_row;
  logic [15:0] wait_dec;

  // request taken when the result slot is free or drains this cycle
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_ticks_q   <= SettleTicksRst;
      scan_gap_ticks_q <= ScanGapTicksRst;
      stable_needed_q  <= StableNeededRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SETTLE_TICKS:   settle_ticks_q   <= cfg_data_i[7:0];
        CFG_SCAN_GAP_TICKS: scan_gap_ticks_q <= cfg_data_i;
        CFG_STABLE_NEEDED:  stable_needed_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // active-low row select, one bit cleared
  assign row_byte = ~(8'd1 << row_index_q);

  // columns read active low
  assign pressed = ~shift_byte_q & ColMask;

  // lowest pressed column
  always_comb begin
    first_col = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (pressed[i]) begin
        first_col = 3'(i);
      end
    end
  end

  assign code_full = 7'(row_index_q) * 7'(Cols) + 7'(first_col) + 7'd1;
  assign code      = (pressed != 8'd0) ? code_full[4:0] : 5'd0;
  assign last_row  = ({1'b0, row_index_q} + 4'd1) >= 4'(Rows);
  assign wait_dec  = (wait_count_q != 16'd0) ? wait_count_q - 16'd1 : 16'd0;

  // per-tick sequencer and debounce
  always_comb begin
    phase_d          = phase_q;
    row_index_d      = row_index_q;
    bit_count_d      = bit_count_q;
    shift_byte_d     = shift_byte_q;
    wait_count_d     = wait_count_q;
    last_code_d      = last_code_q;
    repeat_count_d   = repeat_count_q;
    press_reported_d = press_reported_q;
    clk_d   = 1'b0;
    latch_d = 1'b1;
    sout_d  = 1'b1;
    drive_d = 1'b0;
    done_d  = 1'b0;
    press_d = 1'b0;

    case (phase_q)
      PH_SO_SETUP: begin
        drive_d = 1'b1;
        sout_d  = row_byte[~bit_count_q];
        phase_d = PH_SO_CLOCK;
      end
      PH_SO_CLOCK: begin
        drive_d = 1'b1;
        sout_d  = row_byte[~bit_count_q];
        clk_d   = 1'b1;
        if (bit_count_q == 3'd7) begin
          bit_count_d = 3'd0;
          phase_d     = PH_LATCH_A;
        end else begin
          bit_count_d = bit_count_q + 3'd1;
          phase_d     = PH_SO_SETUP;
        end
      end
      PH_LATCH_A: begin
        drive_d      = 1'b1;
        sout_d       = row_byte[0];
        latch_d      = 1'b0;
        wait_count_d = {8'd0, settle_ticks_q};
        phase_d      = (settle_ticks_q == 8'd0) ? PH_LATCH_B : PH_SETTLE;
      end
      PH_SETTLE: begin
        drive_d      = 1'b1;
        sout_d       = row_byte[0];
        wait_count_d = wait_dec;
        if (wait_dec == 16'd0) begin
          phase_d = PH_LATCH_B;
        end
      end
      PH_LATCH_B: begin
        drive_d     = 1'b1;
        sout_d      = row_byte[0];
        latch_d     = 1'b0;
        bit_count_d = 3'd0;
        phase_d     = PH_SI_SAMPLE;
      end
      PH_SI_SAMPLE: begin
        shift_byte_d = {shift_byte_q[6:0], serial_in_i};
        phase_d      = PH_SI_CLOCK;
      end
      PH_SI_CLOCK: begin
        clk_d = 1'b1;
        if (bit_count_q != 3'd7) begin
          bit_count_d = bit_count_q + 3'd1;
          phase_d     = PH_SI_SAMPLE;
        end else begin
          bit_count_d = 3'd0;
          if ((pressed != 8'd0) || last_row) begin
            done_d = 1'b1;
            // debounce: equal codes count up, a new code starts over
            if (code == last_code_q) begin
              if (repeat_count_q != 8'hFF) begin
                repeat_count_d = repeat_count_q + 8'd1;
              end
            end else begin
              repeat_count_d   = 8'd0;
              press_reported_d = 1'b0;
              last_code_d      = code;
            end
            if ((repeat_count_d >= {4'd0, stable_needed_q}) && (code != 5'd0) &&
                !press_reported_d) begin
              press_reported_d = 1'b1;
              press_d          = 1'b1;
            end
            row_index_d  = 3'd0;
            wait_count_d = scan_gap_ticks_q;
            phase_d      = (scan_gap_ticks_q == 16'd0) ? PH_SO_SETUP : PH_GAP;
          end else begin
            row_index_d = row_index_q + 3'd1;
            phase_d     = PH_SO_SETUP;
          end
        end
      end
      PH_GAP: begin
        wait_count_d = wait_dec;
        if (wait_dec == 16'd0) begin
          phase_d     = PH_SO_SETUP;
          row_index_d = 3'd0;
          bit_count_d = 3'd0;
        end
      end
      default: begin
        phase_d     = PH_SO_SETUP;
        row_index_d = 3'd0;
        bit_count_d = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_SO_SETUP;
      row_index_q      <= 3'd0;
      bit_count_q      <= 3'd0;
      shift_byte_q     <= 8'd0;
      wait_count_q     <= 16'd0;
      last_code_q      <= 5'd0;
      repeat_count_q   <= 8'd0;
      press_reported_q <= 1'b0;
    end else if (accept) begin
      phase_q          <= phase_d;
      row_index_q      <= row_index_d;
      bit_count_q      <= bit_count_d;
      shift_byte_q     <= shift_byte_d;
      wait_count_q     <= wait_count_d;
      last_code_q      <= last_code_d;
      repeat_count_q   <= repeat_count_d;
      press_reported_q <= press_reported_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      clk_q   <= clk_d;
      latch_q <= latch_d;
      sout_q  <= sout_d;
      drive_q <= drive_d;
      done_q  <= done_d;
      press_q <= press_d;
      code_q  <= last_code_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign shift_clock_o = clk_q;
  assign shift_latch_o = latch_q;
  assign serial_out_o  = sout_q;
  assign data_drive_o  = drive_q;
  assign scan_done_o   = done_q;
  assign key_press_o   = press_q;
  assign key_code_o    = code_q;

endmodule

FILE: rtl/core/srks_checker.sv
`timescale 1ns / 1ps

module srks_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        shift_clock_o,
  input logic        shift_latch_o,
  input logic        serial_out_o,
  input logic        data_drive_o,
  input logic        scan_done_o,
  input logic        key_press_o,
  input logic [4:0]  key_code_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(key_code_o) &&
      $stable(scan_done_o) && $stable(key_press_o) && $stable(shift_clock_o))
    else $error("stalled result changed");

  // a press only comes with a finished scan and a real key
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_press_o |-> scan_done_o && (key_code_o != 5'd0))
    else $error("press without scan result");

  // scan ends on a shift-in clock tick, data line released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scan_done_o |-> shift_clock_o && !data_drive_o && shift_latch_o)
    else $error("scan result on wrong tick");

  // latch pulses only while driving the row byte, never with a clock
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !shift_latch_o |-> data_drive_o && !shift_clock_o)
    else $error("latch pulse while line released");

  // released line reads as pulled up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_drive_o |-> serial_out_o)
    else $error("released line not high");

endmodule

bind shift_register_keypad_scanner srks_checker u_srks_checker (.*);

FILE: sim/tb_shift_register_keypad_scanner.sv
`timescale 1ns / 1ps

module tb_shift_register_keypad_scanner;
  import srks_pkg::*;

  // cycles without any accepted request before the run is abandoned; the
  // longest legal quiet stretch is the receiver hold-off
  localparam int unsigned WatchdogLimit = 5000;
  // settling time after the last result
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned HoldStart     = 120;
  localparam int unsigned HoldCycles    = 250;
  localparam int unsigned MaxReports    = 10;

  // pin levels and scan status of one tick
  typedef struct packed {
    logic       shift_clock;
    logic       shift_latch;
    logic       serial_out;
    logic       data_drive;
    logic       scan_done;
    logic       key_press;
    logic [4:0] key_code;
  } pin_levels_t;

  // scanner sequencer, debounce and register copy
  typedef struct {
    phase_e      phase;
    logic [2:0]  row;
    logic [2:0]  bit_cnt;
    logic [7:0]  col_shift;
    logic [15:0] wait_cnt;
    logic [4:0]  last_code;
    logic [7:0]  repeats;
    logic        reported;
    logic [7:0]  settle_ticks;
    logic [15:0] scan_gap_ticks;
    logic [3:0]  stable_needed;
  } scanner_state_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        serial_in_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        shift_clock_o;
  logic        shift_latch_o;
  logic        serial_out_o;
  logic        data_drive_o;
  logic        scan_done_o;
  logic        key_press_o;
  logic [4:0]  key_code_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_SETTLE_TICKS;
  logic [15:0] cfg_data_i  = '0;

  shift_register_keypad_scanner u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .serial_in_i   (serial_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .shift_clock_o (shift_clock_o),
    .shift_latch_o (shift_latch_o),
    .serial_out_o  (serial_out_o),
    .data_drive_o  (data_drive_o),
    .scan_done_o   (scan_done_o),
    .key_press_o   (key_press_o),
    .key_code_o    (key_code_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow_st follows accepted requests; lookahead_st runs ahead while the
  // stimulus is built, so the generator knows which tick samples a column
  scanner_state_t shadow_st;
  scanner_state_t lookahead_st;
  logic           pending_ticks[$];
  pin_levels_t    expected_pins[$];

  // keyboard seen by the generator: one active-high column mask per row,
  // bits at or above the column count included
  logic [7:0]  held_keys [Rows];
  int unsigned keep_pct;
  int unsigned max_row;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  pin_levels_t got_pins;
  pin_levels_t want_pins;

  function automatic scanner_state_t scanner_reset();
    scanner_state_t s;
    s.phase          = PH_SO_SETUP;
    s.row            = '0;
    s.bit_cnt        = '0;
    s.col_shift      = '0;
    s.wait_cnt       = '0;
    s.last_code      = '0;
    s.repeats        = '0;
    s.reported       = 1'b0;
    s.settle_ticks   = SettleTicksRst;
    s.scan_gap_ticks = ScanGapTicksRst;
    s.stable_needed  = StableNeededRst;
    return s;
  endfunction

  // one tick of the scanner: pin levels out, state advanced in place
  function automatic pin_levels_t scan_tick(inout scanner_state_t s, input logic sin);
    pin_levels_t p;
    logic [7:0]  row_sel;
    logic [7:0]  pressed;
    logic [4:0]  code;
    int unsigned col;
    p             = '0;
    p.shift_latch = 1'b1;
    p.serial_out  = 1'b1;
    row_sel       = ~(8'd1 << s.row);
    case (s.phase)
      PH_SO_SETUP, PH_SO_CLOCK: begin
        // row select byte, msb first, same data on setup and clock ticks
        p.data_drive = 1'b1;
        p.serial_out = row_sel[3'd7 - s.bit_cnt];
        if (s.phase == PH_SO_SETUP) begin
          s.phase = PH_SO_CLOCK;
        end else begin
          p.shift_clock = 1'b1;
          if (s.bit_cnt == 3'd7) begin
            s.bit_cnt = '0;
            s.phase   = PH_LATCH_A;
          end else begin
            s.bit_cnt = s.bit_cnt + 3'd1;
            s.phase   = PH_SO_SETUP;
          end
        end
      end
      PH_LATCH_A: begin
        p.data_drive  = 1'b1;
        p.serial_out  = row_sel[0];
        p.shift_latch = 1'b0;
        s.wait_cnt    = 16'(s.settle_ticks);
        s.phase       = (s.wait_cnt == '0) ? PH_LATCH_B : PH_SETTLE;
      end
      PH_SETTLE: begin
        p.data_drive = 1'b1;
        p.serial_out = row_sel[0];
        if (s.wait_cnt != '0) s.wait_cnt = s.wait_cnt - 16'd1;
        if (s.wait_cnt == '0) s.phase = PH_LATCH_B;
      end
      PH_LATCH_B: begin
        p.data_drive  = 1'b1;
        p.serial_out  = row_sel[0];
        p.shift_latch = 1'b0;
        s.bit_cnt     = '0;
        s.phase       = PH_SI_SAMPLE;
      end
      PH_SI_SAMPLE: begin
        s.col_shift = {s.col_shift[6:0], sin};
        s.phase     = PH_SI_CLOCK;
      end
      PH_SI_CLOCK: begin
        p.shift_clock = 1'b1;
        if (s.bit_cnt != 3'd7) begin
          s.bit_cnt = s.bit_cnt + 3'd1;
          s.phase   = PH_SI_SAMPLE;
        end else begin
          pressed   = ~s.col_shift & ColMask;
          s.bit_cnt = '0;
          if (pressed != '0 || int'(s.row) + 1 >= Rows) begin
            code = '0;
            if (pressed != '0) begin
              col = 0;
              while (col < 7 && !pressed[col]) col++;
              code = 5'(int'(s.row) * Cols + col + 1);
            end
            p.scan_done = 1'b1;
            // debounce: repeats saturate, a new code restarts the hold
            if (code == s.last_code) begin
              if (s.repeats != 8'hFF) s.repeats = s.repeats + 8'd1;
            end else begin
              s.repeats   = '0;
              s.reported  = 1'b0;
              s.last_code = code;
            end
            if (s.repeats >= 8'(s.stable_needed) && code != '0 && !s.reported) begin
              s.reported  = 1'b1;
              p.key_press = 1'b1;
            end
            s.row      = '0;
            s.wait_cnt = s.scan_gap_ticks;
            s.phase    = (s.wait_cnt == '0) ? PH_SO_SETUP : PH_GAP;
          end else begin
            s.row   = s.row + 3'd1;
            s.phase = PH_SO_SETUP;
          end
        end
      end
      PH_GAP: begin
        if (s.wait_cnt != '0) s.wait_cnt = s.wait_cnt - 16'd1;
        if (s.wait_cnt == '0) begin
          s.phase   = PH_SO_SETUP;
          s.row     = '0;
          s.bit_cnt = '0;
        end
      end
      default: begin
        s.phase   = PH_SO_SETUP;
        s.row     = '0;
        s.bit_cnt = '0;
      end
    endcase
    p.key_code = s.last_code;
    return p;
  endfunction

  function automatic void push_tick(logic sin);
    void'(scan_tick(lookahead_st, sin));
    pending_ticks.push_back(sin);
  endfunction

  // mostly well-formed scans of a held keyboard, with contact bounce on
  // some column samples and random levels on ticks that ignore the line
  task automatic queue_ticks(int unsigned count);
    int unsigned kind;
    int unsigned col;
    logic        sin;
    repeat (count) begin
      if (lookahead_st.phase == PH_SO_SETUP && lookahead_st.row == '0 &&
          lookahead_st.bit_cnt == '0 && $urandom_range(0, 99) >= keep_pct) begin
        // new keyboard for this scan
        kind = $urandom_range(0, 9);
        foreach (held_keys[r]) held_keys[r] = '0;
        if (kind >= 3 && kind <= 7) begin
          col = ($urandom_range(0, 99) < 80) ? $urandom_range(0, Cols - 1)
                                             : $urandom_range(Cols, 7);
          held_keys[$urandom_range(0, max_row)][col] = 1'b1;
        end else if (kind == 8) begin
          repeat (2) held_keys[$urandom_range(0, max_row)][$urandom_range(0, 7)] = 1'b1;
        end else if (kind == 9) begin
          foreach (held_keys[r]) held_keys[r] = 8'($urandom);
        end
      end
      if (lookahead_st.phase == PH_SI_SAMPLE) begin
        // columns read back active low, highest bit first
        sin = ~held_keys[lookahead_st.row][3'd7 - lookahead_st.bit_cnt];
        if ($urandom_range(0, 99) < 3) sin = ~sin;
      end else begin
        sin = 1'($urandom_range(0, 1));
      end
      push_tick(sin);
    end
  endtask

  // idle means nothing queued, nothing offered and nothing outstanding
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || expected_pins.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i);
    while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SETTLE_TICKS: begin
        shadow_st.settle_ticks    = data[7:0];
        lookahead_st.settle_ticks = data[7:0];
      end
      CFG_SCAN_GAP_TICKS: begin
        shadow_st.scan_gap_ticks    = data;
        lookahead_st.scan_gap_ticks = data;
      end
      CFG_STABLE_NEEDED: begin
        shadow_st.stable_needed    = data[3:0];
        lookahead_st.stable_needed = data[3:0];
      end
      default: ;
    endcase
  endtask

  // upper data bits beyond a register's width carry junk on purpose
  task automatic run_setting(logic [7:0] settle, logic [15:0] gap, logic [3:0] stable,
                             int unsigned keep, int unsigned rows_used,
                             int unsigned count);
    write_reg(CFG_SETTLE_TICKS, {8'($urandom), settle});
    write_reg(CFG_SCAN_GAP_TICKS, gap);
    write_reg(CFG_STABLE_NEEDED, {12'($urandom), stable});
    keep_pct = keep;
    max_row  = rows_used;
    queue_ticks(count);
    wait_idle();
  endtask

  // sender: a request stays offered, unchanged, until it is taken
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_pins.push_back(scan_tick(shadow_st, serial_in_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i  <= 1'b1;
          serial_in_i <= pending_ticks.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result against the oldest expectation and drives
  // the stall, with one long hold-off so the block backs up to its input
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        got_pins = {shift_clock_o, shift_latch_o, serial_out_o, data_drive_o,
                    scan_done_o, key_press_o, key_code_o};
        if (expected_pins.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want_pins = expected_pins.pop_front();
          if (got_pins !== want_pins) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("result %0d expected clk %b latch %b out %b drive %b done %b press %b code %0d",
                       results_seen, want_pins.shift_clock, want_pins.shift_latch,
                       want_pins.serial_out, want_pins.data_drive, want_pins.scan_done,
                       want_pins.key_press, want_pins.key_code);
              $display("result %0d actual   clk %b latch %b out %b drive %b done %b press %b code %0d",
                       results_seen, got_pins.shift_clock, got_pins.shift_latch,
                       got_pins.serial_out, got_pins.data_drive, got_pins.scan_done,
                       got_pins.key_press, got_pins.key_code);
            end
          end
        end
        if (results_seen == HoldStart) hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no request taken on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    shadow_st    = scanner_reset();
    lookahead_st = scanner_reset();
    foreach (held_keys[r]) held_keys[r] = '0;
    keep_pct      = 70;
    max_row       = Rows - 1;
    send_idle_pct = 33;
    recv_idle_pct = 61;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short directed run on the reset settings, both line levels
    for (int i = 0; i < 25; i++) push_tick((i % 3) != 1);
    wait_idle();

    // zero settle, zero gap, immediate report on the first nonzero code
    run_setting(8'd0, 16'd0, 4'd0, 60, Rows - 1, 200);
    run_setting(8'd1, 16'd3, 4'd1, 70, Rows - 1, 150);

    send_idle_pct = 61;
    recv_idle_pct = 33;
    // longest settle between the latch pulses
    run_setting(8'd255, 16'd1, 4'd2, 70, 0, 300);
    // longest debounce: a key in the first row held over many short scans
    run_setting(8'd0, 16'd0, 4'd15, 98, 0, 600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // longest gap, entered after the first completed scan
    run_setting(8'd2, 16'hFFFF, 4'd3, 70, Rows - 1, 100);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
